FILE: hdl/closed_cardinal_spline_arc_stepper_top_assert.svh
// Assertion macros for the cardinal spline arc stepper.
// Used by the controller and top level; no other dependencies.
`ifndef CLOSED_CARDINAL_SPLINE_ARC_STEPPER_TOP_ASSERT_SVH
`define CLOSED_CARDINAL_SPLINE_ARC_STEPPER_TOP_ASSERT_SVH

// implication checked on every clock, off during reset
`define CSAS_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define CSAS_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: hdl/csas_pkg.sv
// Shared types, constants and helpers for the cardinal spline arc stepper.
// No dependencies.
package csas_pkg;
  localparam int MAX_POINTS = 64;
  localparam int PARAM_STEP = 655;
  localparam int MAX_STEPS  = 4096;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);
  localparam int ONE_Q16    = 65536;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_EVAL  = 2'd1;
  localparam logic [1:0] FUNC_ADV   = 2'd2;

  localparam logic [0:0] REG_COUNT   = 1'b0;
  localparam logic [0:0] REG_TENSION = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,  // load start parameter, reduce it
    OP_EVAL  = 4'd2,  // evaluate point at current parameter
    OP_STEP  = 4'd3,  // move parameter one step
    OP_CHORD = 4'd4,  // add chord length to the walked distance
    OP_CLEAR = 4'd5   // zero result
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;      // current op finished
    logic reached;   // acc >= target
    logic zero_trav;
  } dp_sts_t;
endpackage

FILE: hdl/closed_cardinal_spline_arc_stepper_top.sv
// Top level of the closed cardinal spline arc stepper.
// Depends on csas_pkg, csas_ctrl, csas_datapath and the assertion header.
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   func, point_index, coords, param, travel
//  out      output     out_valid/out_stall pos_x/y/z, new_param, limit_hit
//  cfg      input      cfg_we              cfg_index, cfg_wdata
//
// Write and unused codes clear the result and go straight to output. Evaluate time
// is set by the one-multiply-per-cycle basis sequence and the table reads, plus one
// subtract per loop length taken off the parameter (up to 63).
// Advance: the same load, reduction and evaluate, plus per step a parameter move,
// an evaluate and a chord with a 25-iteration sqrt.
// One request at a time; in_stall is high until the result is taken.
// Synchronous active-low reset; tables are not cleared.
`include "closed_cardinal_spline_arc_stepper_top_assert.svh"
module closed_cardinal_spline_arc_stepper_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [5:0]         in_point_index,
  input  logic signed [23:0] in_coord_x,
  input  logic signed [23:0] in_coord_y,
  input  logic signed [23:0] in_coord_z,
  input  logic [21:0]        in_curve_param,
  input  logic signed [23:0] in_travel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [23:0] out_pos_z,
  output logic [21:0]        out_new_param,
  output logic               out_limit_hit,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [16:0]        cfg_wdata
);
  import csas_pkg::*;

  logic [6:0]  count_r;
  logic [16:0] tension_r;
  logic signed [23:0] trav_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic cmd_go, wr_en, hit, adv;
  logic [21:0] dp_param;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 7'd4;
      tension_r <= 17'(ONE_Q16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT:   count_r <= cfg_wdata[6:0];
        REG_TENSION: tension_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      trav_r <= in_travel;
    end
  end

  csas_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .out_valid(out_valid), .out_stall(out_stall),
    .wr_en(wr_en), .cmd(cmd), .cmd_go(cmd_go), .sts(sts),
    .limit_hit(hit), .adv_mode(adv));

  csas_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_go(cmd_go), .sts(sts),
    .wr_en(wr_en), .wr_idx(in_point_index), .wr_x(in_coord_x), .wr_y(in_coord_y),
    .wr_z(in_coord_z), .start_param(in_curve_param), .trav(trav_r),
    .point_count(count_r), .tension_q16(tension_r),
    .pos_x(out_pos_x), .pos_y(out_pos_y), .pos_z(out_pos_z), .param(dp_param));

  assign out_new_param = adv ? dp_param : '0;
  assign out_limit_hit = hit;

  `CSAS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
  `CSAS_ASSERT_IMP(a_stall, clk, rst_n, out_valid, in_stall, "request taken while result waits")
  `CSAS_ASSERT_IMP(a_np, clk, rst_n, out_valid, out_new_param < 22'h3FFFFF || adv, "param bad")
endmodule

FILE: hdl/csas_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module csas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/csas_datapath.sv
// Datapath: point tables, spline evaluator, chord square root, accumulator.
// Depends on csas_pkg and csas_ram.
module csas_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  csas_pkg::dp_cmd_t       cmd,
  input  logic                    cmd_go,
  output csas_pkg::dp_sts_t       sts,
  input  logic                    wr_en,
  input  logic [5:0]              wr_idx,
  input  logic signed [23:0]      wr_x,
  input  logic signed [23:0]      wr_y,
  input  logic signed [23:0]      wr_z,
  input  logic [21:0]             start_param,
  input  logic signed [23:0]      trav,
  input  logic [6:0]              point_count,
  input  logic [16:0]             tension_q16,
  output logic signed [23:0]      pos_x,
  output logic signed [23:0]      pos_y,
  output logic signed [23:0]      pos_z,
  output logic [21:0]             param
);
  import csas_pkg::*;

  localparam int LOOP_W = CNT_W + 16;

  logic [CNT_W-1:0] n_eff;
  logic [16:0] s_eff;
  always_comb begin
    if (point_count == 7'd0) begin
      n_eff = CNT_W'(1);
    end else if (point_count > 7'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = CNT_W'(point_count);
    end
    s_eff = (tension_q16 > 17'(ONE_Q16)) ? 17'(ONE_Q16) : tension_q16;
  end
  logic [LOOP_W-1:0] loop_len;
  assign loop_len = {n_eff, 16'd0};

  // parameter register and reduction by repeated subtract
  logic [LOOP_W-1:0] p_r;
  logic [21:0] red_r;
  logic        reducing_r;

  // eval sequencer
  logic [4:0] ev_r;
  logic       ev_busy_r;
  logic [IDX_W-1:0] seg_r;
  logic signed [17:0] t_r;
  logic signed [17:0] t2_r, t3_r;
  logic signed [18:0] w_r [4];
  logic signed [49:0] acc_x_r, acc_y_r, acc_z_r;
  logic signed [23:0] cur_x_r, cur_y_r, cur_z_r;
  logic signed [23:0] prv_x_r, prv_y_r, prv_z_r;

  logic [IDX_W-1:0] raddr;
  logic signed [23:0] rx, ry, rz;

  csas_ram #(.WIDTH(24), .DEPTH(MAX_POINTS)) u_x (
    .clk(clk), .we(wr_en), .waddr(IDX_W'(wr_idx)), .wdata(wr_x), .raddr(raddr), .rdata(rx));
  csas_ram #(.WIDTH(24), .DEPTH(MAX_POINTS)) u_y (
    .clk(clk), .we(wr_en), .waddr(IDX_W'(wr_idx)), .wdata(wr_y), .raddr(raddr), .rdata(ry));
  csas_ram #(.WIDTH(24), .DEPTH(MAX_POINTS)) u_z (
    .clk(clk), .we(wr_en), .waddr(IDX_W'(wr_idx)), .wdata(wr_z), .raddr(raddr), .rdata(rz));

  // neighbor index by ev step: neighbor k is read when the low ev bits equal k (k=0..3)
  logic [IDX_W:0] nb;
  always_comb begin
    case (ev_r[1:0])
      2'd0: nb = (seg_r == '0) ? {1'b0, IDX_W'(n_eff - CNT_W'(1))}
                               : {1'b0, seg_r} - 1'b1;
      2'd1: nb = {1'b0, seg_r};
      2'd2: nb = {1'b0, seg_r} + 1'b1;
      default: nb = {1'b0, seg_r} + 2'd2;
    endcase
    if (nb >= (IDX_W+1)'(n_eff)) begin
      nb = nb - (IDX_W+1)'(n_eff);
    end
    if (n_eff == CNT_W'(1)) begin
      nb = '0;
    end
    raddr = nb[IDX_W-1:0];
  end

  // segment of p: integer part modulo n, p already reduced below loop_len
  // basis: one multiply per cycle
  logic signed [23:0] mul_a, mul_b;
  logic signed [47:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [19:0] b0, b1, b2, b3;
  assign b0 = 20'(-t3_r + 2 * t2_r - t_r);
  assign b1 = 20'(t2_r - t3_r);
  assign b2 = 20'(t3_r - 2 * t2_r + t_r);
  assign b3 = 20'(t3_r - t2_r);

  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    logic signed [49:0] f;
    begin
      f = v >>> 16;
      if (f > 50'sd8388607) sat24 = 24'sh7FFFFF;
      else if (f < -50'sd8388608) sat24 = -24'sh800000;
      else sat24 = f[23:0];
    end
  endfunction

  // sqrt unit: 2 bits per cycle over 50-bit radicand
  logic [49:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [36:0] chord_acc_r;
  logic [23:0] target;
  assign target = trav[23] ? 24'(-trav) : 24'(trav);
  logic signed [24:0] dx, dy, dz;
  assign dx = prv_x_r - cur_x_r;
  assign dy = prv_y_r - cur_y_r;
  assign dz = prv_z_r - cur_z_r;

  logic [49:0] sq_sum_r;
  logic [1:0]  ch_ph_r;
  logic        done_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ev_r)
      5'd1: begin mul_a = 24'(t_r); mul_b = 24'(t_r); end
      5'd2: begin mul_a = 24'(t2_r); mul_b = 24'(t_r); end
      5'd3: begin mul_a = 24'(signed'({1'b0, s_eff})); mul_b = 24'(b0); end
      5'd4: begin mul_a = 24'(signed'({1'b0, s_eff})); mul_b = 24'(b1); end
      5'd5: begin mul_a = 24'(signed'({1'b0, s_eff})); mul_b = 24'(b2); end
      5'd6: begin mul_a = 24'(signed'({1'b0, s_eff})); mul_b = 24'(b3); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // weight products use three multipliers, one per axis, in later steps
  logic signed [43:0] px, py, pz;
  logic [1:0] wi;
  assign wi = ev_r[1:0] - 2'd1;
  assign px = w_r[wi] * rx;
  assign py = w_r[wi] * ry;
  assign pz = w_r[wi] * rz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= '0;
      ev_busy_r <= 1'b0;
      reducing_r <= 1'b0;
      done_r <= 1'b0;
      ch_ph_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd_go) begin
        case (cmd.op)
          OP_CLEAR: begin
            cur_x_r <= '0; cur_y_r <= '0; cur_z_r <= '0;
            p_r <= '0;
            done_r <= 1'b1;
          end
          OP_LOAD: begin
            red_r <= start_param;
            reducing_r <= 1'b1;
            chord_acc_r <= '0;
          end
          OP_STEP: begin
            if (!trav[23]) begin
              p_r <= (p_r + LOOP_W'(PARAM_STEP) >= loop_len)
                     ? p_r + LOOP_W'(PARAM_STEP) - loop_len : p_r + LOOP_W'(PARAM_STEP);
            end else begin
              p_r <= (p_r < LOOP_W'(PARAM_STEP))
                     ? p_r + loop_len - LOOP_W'(PARAM_STEP) : p_r - LOOP_W'(PARAM_STEP);
            end
            done_r <= 1'b1;
          end
          OP_EVAL: begin
            prv_x_r <= cur_x_r; prv_y_r <= cur_y_r; prv_z_r <= cur_z_r;
            t_r <= {2'b0, p_r[15:0]};
            seg_r <= IDX_W'(p_r[LOOP_W-1:16]);
            ev_r <= 5'd1;
            ev_busy_r <= 1'b1;
          end
          OP_CHORD: begin
            sq_sum_r <= 50'(dx * dx) + 50'(dy * dy) + 50'(dz * dz);
            ch_ph_r <= 2'd1;
          end
          default: ;
        endcase
      end
      // reduce modulo loop length by subtracting loop_len chunks
      if (reducing_r) begin
        if (LOOP_W'(red_r) >= loop_len) begin
          red_r <= red_r - 22'(loop_len);
        end else begin
          p_r <= LOOP_W'(red_r);
          reducing_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
      if (ev_busy_r) begin
        ev_r <= (ev_r == 5'd13) ? 5'd0 : ev_r + 5'd1;
        case (ev_r)
          5'd1: t2_r <= 18'(mul_p >>> 16);
          5'd2: t3_r <= 18'(mul_p >>> 16);
          5'd3: w_r[0] <= 19'(mul_p >>> 16);
          5'd4: w_r[1] <= 19'(2 * t3_r - 3 * t2_r + ONE_Q16) + 19'(mul_p >>> 16);
          5'd5: w_r[2] <= 19'(-2 * t3_r + 3 * t2_r) + 19'(mul_p >>> 16);
          5'd6: w_r[3] <= 19'(mul_p >>> 16);
          default: ;
        endcase
        // ram reads issued at ev 8..11, data at 9..12; reuse ev low bits
        if (ev_r == 5'd7) begin
          acc_x_r <= '0; acc_y_r <= '0; acc_z_r <= '0;
        end
        if (ev_r >= 5'd9 && ev_r <= 5'd12) begin
          acc_x_r <= acc_x_r + 50'(px);
          acc_y_r <= acc_y_r + 50'(py);
          acc_z_r <= acc_z_r + 50'(pz);
        end
        if (ev_r == 5'd13) begin
          cur_x_r <= sat24(acc_x_r);
          cur_y_r <= sat24(acc_y_r);
          cur_z_r <= sat24(acc_z_r);
          ev_busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
      case (ch_ph_r)
        2'd1: begin
          sq_v_r <= sq_sum_r;
          sq_res_r <= '0;
          sq_bit_r <= 50'd1 << 48;
          ch_ph_r <= 2'd2;
        end
        2'd2: begin
          if (sq_bit_r == '0) begin
            chord_acc_r <= chord_acc_r + 37'(sq_res_r);
            ch_ph_r <= 2'd0;
            done_r <= 1'b1;
          end else begin
            if (sq_v_r >= sq_res_r + sq_bit_r) begin
              sq_v_r <= sq_v_r - (sq_res_r + sq_bit_r);
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.done = done_r;
  assign sts.reached = chord_acc_r >= 37'(target);
  assign sts.zero_trav = (trav == '0);
  assign pos_x = cur_x_r;
  assign pos_y = cur_y_r;
  assign pos_z = cur_z_r;
  assign param = 22'(p_r);
endmodule

FILE: hdl/csas_ctrl.sv
// Controller state machine: sequences clear, load, evaluate, step and chord ops.
// Depends on csas_pkg and the assertion macro header.
`include "closed_cardinal_spline_arc_stepper_top_assert.svh"
module csas_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              wr_en,
  output csas_pkg::dp_cmd_t cmd,
  output logic              cmd_go,
  input  csas_pkg::dp_sts_t sts,
  output logic              limit_hit,
  output logic              adv_mode
);
  import csas_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_EVAL0 = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_STEP  = 8'b0001_0000,
    S_EVAL  = 8'b0010_0000,
    S_CHORD = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic hit_r, hit_nxt, adv_r, adv_nxt, wait_r, wait_nxt;
  logic accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign wr_en = accept && in_func == FUNC_WRITE;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    steps_nxt = steps_r;
    hit_nxt = hit_r;
    adv_nxt = adv_r;
    wait_nxt = 1'b0;
    cmd.op = OP_NONE;
    cmd_go = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          steps_nxt = '0;
          hit_nxt = 1'b0;
          adv_nxt = (in_func == FUNC_ADV);
          if (in_func == FUNC_EVAL || in_func == FUNC_ADV) begin
            cmd.op = OP_LOAD; cmd_go = 1'b1; state_nxt = S_LOAD;
          end else begin
            cmd.op = OP_CLEAR; cmd_go = 1'b1; state_nxt = S_OUT;
          end
        end
      end
      S_LOAD: if (sts.done) begin
        cmd.op = OP_EVAL; cmd_go = 1'b1; state_nxt = S_EVAL0;
      end
      S_EVAL0: if (sts.done) state_nxt = adv_r ? S_CHECK : S_OUT;
      S_CHECK: begin
        if (sts.zero_trav || sts.reached) begin
          state_nxt = S_OUT;
        end else if (steps_r >= STEP_W'(MAX_STEPS)) begin
          hit_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          cmd.op = OP_STEP; cmd_go = 1'b1; state_nxt = S_STEP;
        end
      end
      S_STEP: if (sts.done) begin
        cmd.op = OP_EVAL; cmd_go = 1'b1; state_nxt = S_EVAL;
      end
      S_EVAL: if (sts.done) begin
        cmd.op = OP_CHORD; cmd_go = 1'b1; state_nxt = S_CHORD;
      end
      S_CHORD: if (sts.done) begin
        steps_nxt = steps_r + STEP_W'(1);
        wait_nxt = 1'b1;
        state_nxt = S_CHECK;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      steps_r <= '0;
      hit_r <= 1'b0;
      adv_r <= 1'b0;
      wait_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      steps_r <= steps_nxt;
      hit_r <= hit_nxt;
      adv_r <= adv_nxt;
      wait_r <= wait_nxt;
    end
  end

  assign limit_hit = hit_r;
  assign adv_mode = adv_r && !wait_r;

  `CSAS_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
  `CSAS_ASSERT_IMP(a_steps, clk, rst_n, 1'b1, steps_r <= STEP_W'(MAX_STEPS), "step overrun")
  `CSAS_ASSERT_IMP(a_hit, clk, rst_n, hit_r && state_r == S_OUT, adv_r, "limit flag off advance")
endmodule

FILE: bench/testbench.sv
// Self-checking bench for the closed cardinal spline arc stepper top level.
// Drives write, evaluate, advance and unused-code requests and checks every result
// against a cycle-free prediction of the curve math; depends on csas_pkg and the top level.
`timescale 1ns / 1ps
module testbench;
  import csas_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int STEP_CAP = 24;
  localparam int CYCLE_LIMIT = 8000000;

  typedef struct {
    logic [1:0]         func;
    logic [5:0]         slot;
    logic signed [23:0] x, y, z;
    logic [21:0]        param;
    logic signed [23:0] trav;
  } request_t;

  typedef struct {
    logic signed [23:0] x, y, z;
    logic [21:0]        param;
    logic               hit;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [5:0] in_point_index = '0;
  logic signed [23:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic [21:0] in_curve_param = '0;
  logic signed [23:0] in_travel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_pos_x, out_pos_y, out_pos_z;
  logic [21:0] out_new_param;
  logic out_limit_hit;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [16:0] cfg_wdata = '0;

  closed_cardinal_spline_arc_stepper_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // copy 0 follows the queued stream, copy 1 follows accepted requests
  longint pts_x[2][MAX_POINTS], pts_y[2][MAX_POINTS], pts_z[2][MAX_POINTS];
  logic [6:0]  loop_cnt = 7'd4;
  logic [16:0] tension = 17'd65536;
  bit written[MAX_POINTS];

  request_t pending[$];
  request_t in_flight;
  point_t   expected[$];
  int fails = 0;
  int results_seen = 0;
  int cycles = 0;

  function automatic longint loop_points();
    if (loop_cnt == 0) return 1;
    if (loop_cnt > MAX_POINTS) return MAX_POINTS;
    return loop_cnt;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void curve_at(int c, longint p, output longint pos[3]);
    longint n = loop_points();
    longint seg = (p >> 16) % n;
    longint t = p & 16'hFFFF;
    longint t2 = (t * t) >> 16;
    longint t3 = (t2 * t) >> 16;
    longint s = (tension > ONE_Q16) ? ONE_Q16 : longint'(tension);
    longint w[4];
    longint idx[4];
    idx[0] = (seg + n - 1) % n;
    idx[1] = seg;
    idx[2] = (seg + 1) % n;
    idx[3] = (seg + 2) % n;
    w[0] = (s * (-t3 + 2 * t2 - t)) >>> 16;
    w[1] = (2 * t3 - 3 * t2 + ONE_Q16) + ((s * (t2 - t3)) >>> 16);
    w[2] = (-2 * t3 + 3 * t2) + ((s * (t3 - 2 * t2 + t)) >>> 16);
    w[3] = (s * (t3 - t2)) >>> 16;
    pos = '{0, 0, 0};
    for (int k = 0; k < 4; k++) begin
      pos[0] += w[k] * pts_x[c][idx[k]];
      pos[1] += w[k] * pts_y[c][idx[k]];
      pos[2] += w[k] * pts_z[c][idx[k]];
    end
    for (int k = 0; k < 3; k++) pos[k] = sat24(pos[k] >>> 16);
  endfunction

  function automatic void apply_request(int c, request_t r, output point_t o,
                                        output int steps);
    longint pos[3] = '{0, 0, 0};
    longint nxt[3];
    longint len, p, tr;
    longint unsigned target, walked, sq;
    o = '{0, 0, 0, 0, 0};
    steps = 0;
    case (r.func)
      FUNC_WRITE: begin
        pts_x[c][r.slot] = r.x;
        pts_y[c][r.slot] = r.y;
        pts_z[c][r.slot] = r.z;
      end
      FUNC_EVAL: begin
        curve_at(c, r.param, pos);
      end
      FUNC_ADV: begin
        len = loop_points() << 16;
        p = longint'(r.param) % len;
        tr = r.trav;
        target = (tr < 0) ? -tr : tr;
        walked = 0;
        curve_at(c, p, pos);
        while (walked < target) begin
          if (steps >= MAX_STEPS) begin
            o.hit = 1'b1;
            break;
          end
          if (tr > 0) begin
            p += PARAM_STEP;
            if (p >= len) p -= len;
          end else begin
            p -= PARAM_STEP;
            if (p < 0) p += len;
          end
          curve_at(c, p, nxt);
          sq = 0;
          for (int k = 0; k < 3; k++) sq += (pos[k] - nxt[k]) * (pos[k] - nxt[k]);
          walked += root_floor(sq);
          pos = nxt;
          steps++;
        end
        o.param = 22'(p);
      end
      default: ;
    endcase
    if (r.func != FUNC_WRITE) begin
      o.x = 24'(pos[0]);
      o.y = 24'(pos[1]);
      o.z = 24'(pos[2]);
    end
  endfunction

  // driver
  int burst = 0, gap = 0;
  always @(posedge clk) begin
    point_t res;
    int steps;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_request(1, in_flight, res, steps);
        expected.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_flight = pending.pop_front();
          in_func <= in_flight.func;
          in_point_index <= in_flight.slot;
          in_coord_x <= in_flight.x;
          in_coord_y <= in_flight.y;
          in_coord_z <= in_flight.z;
          in_curve_param <= in_flight.param;
          in_travel <= in_flight.trav;
          in_valid <= 1'b1;
          if (burst > 0) begin
            burst--;
          end else begin
            burst = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  int hold_left = 0;
  int stall_mode = 0;
  bit long_hold_done = 0;
  always @(posedge clk) begin
    point_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[closed_cardinal_spline_arc_stepper_top] ERROR");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          e = expected.pop_front();
          if (out_pos_x !== e.x) begin
            $error("pos_x exp %0d got %0d", e.x, out_pos_x); fails++;
          end
          if (out_pos_y !== e.y) begin
            $error("pos_y exp %0d got %0d", e.y, out_pos_y); fails++;
          end
          if (out_pos_z !== e.z) begin
            $error("pos_z exp %0d got %0d", e.z, out_pos_z); fails++;
          end
          if (out_new_param !== e.param) begin
            $error("new_param exp %0d got %0d", e.param, out_new_param); fails++;
          end
          if (out_limit_hit !== e.hit) begin
            $error("limit_hit exp %0d got %0d", e.hit, out_limit_hit); fails++;
          end
        end
      end
      if (!long_hold_done && results_seen == 120) begin
        long_hold_done = 1;
        hold_left = 600;
      end
      if (cycles % 128 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_mode == 0) begin
        out_stall <= 1'b0;
      end else if (stall_mode == 1) begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic request_t noise_request();
    request_t r;
    r.func = 2'($urandom_range(0, 3));
    r.slot = 6'($urandom);
    r.x = 24'($urandom);
    r.y = 24'($urandom);
    r.z = 24'($urandom);
    r.param = 22'($urandom);
    r.trav = 24'($urandom);
    return r;
  endfunction

  task automatic queue_request(request_t r);
    point_t o;
    int steps;
    if (r.func == FUNC_WRITE) written[r.slot] = 1;
    apply_request(0, r, o, steps);
    pending.push_back(r);
  endtask

  task automatic queue_write(int slot, longint x, longint y, longint z);
    request_t r = noise_request();
    r.func = FUNC_WRITE;
    r.slot = 6'(slot);
    r.x = 24'(x);
    r.y = 24'(y);
    r.z = 24'(z);
    queue_request(r);
  endtask

  task automatic queue_op(logic [1:0] f, longint param, longint trav);
    request_t r = noise_request();
    r.func = f;
    r.param = 22'(param);
    r.trav = 24'(trav);
    queue_request(r);
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_loop(logic [6:0] cnt, logic [16:0] ten);
    wait_idle();
    write_reg(REG_COUNT, 17'(cnt));
    write_reg(REG_TENSION, ten);
    loop_cnt = cnt;
    tension = ten;
    for (int i = 0; i < loop_points(); i++)
      if (!written[i])
        queue_write(i, $signed($urandom_range(0, 2097151)) - 1048576,
                    $signed($urandom_range(0, 2097151)) - 1048576,
                    $signed($urandom_range(0, 2097151)) - 1048576);
  endtask

  task automatic random_phase(int count);
    request_t r;
    point_t o;
    int steps, pick;
    for (int i = 0; i < count; i++) begin
      r = noise_request();
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        r.func = FUNC_WRITE;
        if ($urandom_range(0, 3) != 0) r.slot = 6'($urandom_range(0, loop_points() - 1));
        if ($urandom_range(0, 9) != 0) begin
          r.x = 24'($signed($urandom_range(0, 2097151)) - 1048576);
          r.y = 24'($signed($urandom_range(0, 2097151)) - 1048576);
          r.z = 24'($signed($urandom_range(0, 2097151)) - 1048576);
        end
      end else if (pick < 60) begin
        r.func = FUNC_EVAL;
      end else if (pick < 95) begin
        r.func = FUNC_ADV;
        r.trav = 24'($signed($urandom_range(0, 131072)) - 65536);
        for (int k = 0; k < 8; k++) begin
          apply_request(0, r, o, steps);
          if (steps <= STEP_CAP) break;
          r.trav = 24'(r.trav / 4);
        end
        apply_request(0, r, o, steps);
        if (steps > STEP_CAP) r.trav = 0;
      end else begin
        r.func = FUNC_UNUSED;
      end
      queue_request(r);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_loop(7'd4, 17'd65536);
    // extreme control points
    queue_write(0, 8388607, -8388608, 0);
    queue_write(1, -8388608, 8388607, 8388607);
    queue_write(2, 0, -8388608, -8388608);
    queue_write(3, 1234567, 0, -4000000);
    queue_op(FUNC_EVAL, 0, 0);
    queue_op(FUNC_EVAL, 22'h3FFFFF, 0);
    queue_op(FUNC_EVAL, 22'h18000, 0);
    queue_op(FUNC_EVAL, 22'h2FFFF, 0);
    queue_op(FUNC_ADV, 22'h3FFFFF, 0);
    queue_op(FUNC_ADV, 22'h10000, 8388607);
    queue_op(FUNC_ADV, 22'h20000, -8388608);
    queue_op(FUNC_ADV, 0, -300000);
    queue_op(FUNC_UNUSED, 22'h12345, 77);
    queue_write(63, -1, -1, -1);
    // a loop collapsed to one spot never covers any distance
    for (int i = 0; i < 4; i++) queue_write(i, 4096, -8192, 12288);
    queue_op(FUNC_ADV, 22'h8000, 5000);
    queue_op(FUNC_EVAL, 22'h28000, 0);
    for (int i = 0; i < 4; i++)
      queue_write(i, $signed($urandom_range(0, 2097151)) - 1048576,
                  $signed($urandom_range(0, 2097151)) - 1048576,
                  $signed($urandom_range(0, 2097151)) - 1048576);
    random_phase(100);
    // sender pause until everything has drained
    wait_idle();
    random_phase(20);
    set_loop(7'd64, 17'd65536);
    random_phase(110);
    set_loop(7'd0, 17'd0);
    random_phase(60);
    set_loop(7'd2, 17'd131071);
    random_phase(90);
    set_loop(7'd100, 17'd40000);
    random_phase(100);
    set_loop(7'd7, 17'($urandom_range(0, 65536)));
    random_phase(100);
    set_loop(7'd3, 17'd65537);
    random_phase(80);
    wait_idle();
    repeat (60) @(posedge clk);
    if (fails == 0) $display("[closed_cardinal_spline_arc_stepper_top] OK");
    else $display("[closed_cardinal_spline_arc_stepper_top] ERROR");
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/csas_pkg.sv
hdl/csas_ram.sv
hdl/csas_datapath.sv
hdl/csas_ctrl.sv
hdl/closed_cardinal_spline_arc_stepper_top.sv
bench/testbench.sv
